[sv/gqi_pkg.sv]
// Shared types, constants and coefficient tables for the gyro quaternion integrator.
// No dependencies; the top level, the multiplier and the divider import this package.
package gqi_pkg;

  localparam int ACC_W = 68;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [31:0]      q30_t;
  typedef logic signed [23:0]      rate_t;

  typedef struct packed {
    logic [1:0] mode;
    rate_t      rate_x;
    rate_t      rate_y;
    rate_t      rate_z;
  } in_t;

  typedef struct packed {
    q30_t r00;
    q30_t r01;
    q30_t r02;
    q30_t r10;
    q30_t r11;
    q30_t r12;
    q30_t r20;
    q30_t r21;
    q30_t r22;
  } out_t;

  // control bundle toward the serial multiplier
  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } mul_req_t;

  // one product term: operand selects and sign
  typedef struct packed {
    logic [1:0] asel;
    logic [1:0] bsel;
    logic       sub;
  } term_t;

  localparam logic [1:0] MODE_RESET = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_ROT   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] QW = 2'd0;
  localparam logic [1:0] QX = 2'd1;
  localparam logic [1:0] QY = 2'd2;
  localparam logic [1:0] QZ = 2'd3;

  localparam logic [1:0] RX = 2'd0;
  localparam logic [1:0] RY = 2'd1;
  localparam logic [1:0] RZ = 2'd2;

  localparam logic [7:0]  TICK_RESET = 8'd2;
  localparam logic [31:0] STEP_DIV   = 32'd131072000;
  localparam q30_t        ONE_Q30    = 32'sd1073741824;

  // Omega(w) * q rows: term j of component i
  function automatic term_t sum_term(input logic [1:0] i, input logic [1:0] j);
    term_t t;
    case ({i, j})
      4'b00_00: t = '{RX, QX, 1'b1};
      4'b00_01: t = '{RY, QY, 1'b1};
      4'b00_10: t = '{RZ, QZ, 1'b1};
      4'b01_00: t = '{RX, QW, 1'b0};
      4'b01_01: t = '{RZ, QY, 1'b0};
      4'b01_10: t = '{RY, QZ, 1'b1};
      4'b10_00: t = '{RY, QW, 1'b0};
      4'b10_01: t = '{RZ, QX, 1'b1};
      4'b10_10: t = '{RX, QZ, 1'b0};
      4'b11_00: t = '{RZ, QW, 1'b0};
      4'b11_01: t = '{RY, QX, 1'b0};
      4'b11_10: t = '{RX, QY, 1'b1};
      default:  t = '{RX, QW, 1'b0};
    endcase
    return t;
  endfunction

  // rotation matrix entry k: two doubled quaternion products
  function automatic term_t mat_term(input logic [3:0] k, input logic j);
    term_t t;
    case ({k, j})
      5'd0:  t = '{QY, QY, 1'b1};
      5'd1:  t = '{QZ, QZ, 1'b1};
      5'd2:  t = '{QX, QY, 1'b0};
      5'd3:  t = '{QZ, QW, 1'b0};
      5'd4:  t = '{QX, QZ, 1'b0};
      5'd5:  t = '{QY, QW, 1'b1};
      5'd6:  t = '{QX, QY, 1'b0};
      5'd7:  t = '{QZ, QW, 1'b1};
      5'd8:  t = '{QX, QX, 1'b1};
      5'd9:  t = '{QZ, QZ, 1'b1};
      5'd10: t = '{QY, QZ, 1'b0};
      5'd11: t = '{QX, QW, 1'b0};
      5'd12: t = '{QX, QZ, 1'b0};
      5'd13: t = '{QY, QW, 1'b0};
      5'd14: t = '{QY, QZ, 1'b0};
      5'd15: t = '{QX, QW, 1'b1};
      5'd16: t = '{QX, QX, 1'b1};
      5'd17: t = '{QY, QY, 1'b1};
      default: t = '{QW, QW, 1'b0};
    endcase
    return t;
  endfunction

endpackage

[sv/gyro_quaternion_integrator.sv]
// Top level: quaternion state, operation sequencer and result register.
// Depends on gqi_pkg, gqi_smul, gqi_sdiv and gqi_sqrt.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------
//  in_     | into      | in_valid/in_stall | in_data  (in_t: mode, rates)
//  out_    | out of    | out_valid/out_stall| out_data (out_t: 3x3 matrix)
//  cfg_    | into      | cfg_valid/cfg_ready| cfg_data (tick_ms, 8 bit)
//
// Identity reset and the unused mode are done in the idle state; an integration step
// runs on the bit-serial multiplier, the divider and the root unit, a matrix on the
// multiplier alone; in_stall stays high until the step is done.
// Reset is synchronous, active low: quaternion to identity, tick_ms to 2.
// A finished matrix waits in the output register while new transactions are taken;
// a later matrix holds in the sequencer until that register frees.
module gyro_quaternion_integrator import gqi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;  // Omega row sums
  localparam logic [3:0] ST_SCL  = 4'd2;  // times tick, plus half divisor
  localparam logic [3:0] ST_DQ   = 4'd3;  // floor divide by step divisor
  localparam logic [3:0] ST_SQ   = 4'd4;  // sum of squares
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_NDIV = 4'd6;  // normalize each component
  localparam logic [3:0] ST_MAT  = 4'd7;  // matrix entries
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam acc_t S32_MAX  = acc_t'(64'sd2147483647);
  localparam acc_t S32_MIN  = acc_t'(-64'sd2147483648);
  localparam acc_t HALF_DIV = acc_t'(STEP_DIV >> 1);
  localparam acc_t ONE_Q60  = acc_t'(1) <<< 60;
  localparam logic signed [33:0] CLAMP_HI = 34'sd1073741824;
  localparam logic signed [33:0] CLAMP_LO = -34'sd1073741824;

  logic [3:0] state_r;
  logic       issued_r;
  logic [1:0] i_r, j_r;
  logic [3:0] k_r;
  q30_t       q_r [4];
  q30_t       p_r [4];
  q30_t       mat_r [9];
  rate_t      wx_r, wy_r, wz_r;
  logic [7:0] tick_r;
  logic [31:0] norm_r;
  logic       dq_neg_r;
  out_t       out_r;
  logic       out_valid_r;

  mul_req_t         mul_req;
  acc_t             mul_a, mul_init, mul_acc;
  q30_t             mul_b;
  logic             mul_done;
  logic             div_start, div_done;
  logic [ACC_W-1:0] div_num, div_quot;
  logic [31:0]      div_den;
  logic             sqrt_start, sqrt_done;
  logic [31:0]      sqrt_root;
  term_t            st, mt;
  logic [31:0]      p_mag;
  acc_t             dq, q_sum;
  logic [63:0]      m_rnd;
  logic signed [33:0] m_q30;
  q30_t             m_sat, n_sat;

  function automatic q30_t sat32(input acc_t v);
    if (v > S32_MAX) return q30_t'(S32_MAX);
    if (v < S32_MIN) return q30_t'(S32_MIN);
    return v[31:0];
  endfunction

  function automatic rate_t rate_sel(input logic [1:0] s, input rate_t x, input rate_t y,
                                     input rate_t z);
    case (s)
      RX:      return x;
      RY:      return y;
      default: return z;
    endcase
  endfunction

  assign st    = sum_term(i_r, j_r);
  assign mt    = mat_term(k_r, j_r[0]);
  assign p_mag = p_r[i_r][31] ? 32'(-p_r[i_r]) : 32'(p_r[i_r]);

  // Drive the shared arithmetic units from the current step.
  always_comb begin
    mul_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    mul_init   = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    unique case (state_r)
      ST_SUM: begin
        mul_req.start = !issued_r;
        mul_req.clr   = (j_r == 2'd0);
        mul_req.sub   = st.sub;
        mul_a         = acc_t'(rate_sel(st.asel, wx_r, wy_r, wz_r));
        mul_b         = q_r[st.bsel];
      end
      ST_SCL: begin
        mul_req.start = !issued_r;
        mul_req.clr   = 1'b1;
        mul_a         = mul_acc;
        mul_b         = q30_t'({24'd0, tick_r});
        mul_init      = HALF_DIV;
      end
      ST_DQ: begin
        // floor division of a negative value: negate, bias up, negate back
        div_start = !issued_r;
        div_num   = mul_acc[ACC_W-1] ? ACC_W'(-mul_acc) + ACC_W'(STEP_DIV - 32'd1)
                                     : ACC_W'(mul_acc);
        div_den   = STEP_DIV;
      end
      ST_SQ: begin
        mul_req.start = !issued_r;
        mul_req.clr   = (i_r == 2'd0);
        mul_a         = acc_t'(p_r[i_r]);
        mul_b         = p_r[i_r];
      end
      ST_ROOT: begin
        sqrt_start = !issued_r;
      end
      ST_NDIV: begin
        div_start = !issued_r;
        div_num   = ACC_W'({p_mag, 30'd0}) + ACC_W'(norm_r[31:1]);
        div_den   = norm_r;
      end
      ST_MAT: begin
        mul_req.start = !issued_r;
        mul_req.clr   = (j_r[0] == 1'b0);
        mul_req.sub   = mt.sub;
        mul_a         = acc_t'(q_r[mt.asel]) <<< 1;
        mul_b         = q_r[mt.bsel];
        mul_init      = (k_r == 4'd0 || k_r == 4'd4 || k_r == 4'd8) ? ONE_Q60 : '0;
      end
      default: ;
    endcase
  end

  // Quotient back to a signed step, added to the old component.
  assign dq    = dq_neg_r ? -acc_t'(div_quot) : acc_t'(div_quot);
  assign q_sum = acc_t'(q_r[i_r]) + dq;

  // Normalized component: restore sign, saturate.
  always_comb begin
    if (p_r[i_r][31]) begin
      n_sat = (div_quot > ACC_W'(33'd2147483648)) ? q30_t'(S32_MIN) : -q30_t'(div_quot[31:0]);
    end else begin
      n_sat = (div_quot > ACC_W'(32'd2147483647)) ? q30_t'(S32_MAX) : q30_t'(div_quot[31:0]);
    end
  end

  // Matrix entry: wrap to 64 bits, round to Q2.30, clamp to +-1.
  assign m_rnd = mul_acc[63:0] + 64'd536870912;
  assign m_q30 = m_rnd[63:30];
  assign m_sat = (m_q30 > CLAMP_HI) ? q30_t'(CLAMP_HI) :
                 (m_q30 < CLAMP_LO) ? q30_t'(CLAMP_LO) : m_q30[31:0];

  gqi_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .init  (mul_init),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  gqi_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  gqi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (mul_acc[63:0]),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      tick_r      <= TICK_RESET;
      q_r[0]      <= ONE_Q30;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) tick_r <= cfg_data;
      // raise on a new matrix, drop once the consumer takes it
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (mul_req.start || div_start || sqrt_start) issued_r <= 1'b1;

      unique case (state_r)
        ST_IDLE: begin
          i_r <= '0;
          j_r <= '0;
          k_r <= '0;
          if (in_valid) begin
            case (in_data.mode)
              MODE_RESET: begin
                q_r[0] <= ONE_Q30;
                q_r[1] <= '0;
                q_r[2] <= '0;
                q_r[3] <= '0;
              end
              MODE_STEP: begin
                wx_r    <= in_data.rate_x;
                wy_r    <= in_data.rate_y;
                wz_r    <= in_data.rate_z;
                state_r <= ST_SUM;
              end
              MODE_ROT: state_r <= ST_MAT;
              default: ;
            endcase
          end
        end
        ST_SUM: if (mul_done) begin
          issued_r <= 1'b0;
          if (j_r == 2'd2) begin
            j_r     <= '0;
            state_r <= ST_SCL;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        ST_SCL: if (mul_done) begin
          issued_r <= 1'b0;
          dq_neg_r <= mul_acc[ACC_W-1];
          state_r  <= ST_DQ;
        end
        ST_DQ: if (div_done) begin
          issued_r   <= 1'b0;
          p_r[i_r]   <= sat32(q_sum);
          i_r        <= i_r + 2'd1;
          state_r    <= (i_r == 2'd3) ? ST_SQ : ST_SUM;
        end
        ST_SQ: if (mul_done) begin
          issued_r <= 1'b0;
          i_r      <= i_r + 2'd1;
          if (i_r == 2'd3) state_r <= ST_ROOT;
        end
        ST_ROOT: if (sqrt_done) begin
          issued_r <= 1'b0;
          norm_r   <= sqrt_root;
          if (sqrt_root == 32'd0) begin
            // degenerate step: fall back to identity
            q_r[0]  <= ONE_Q30;
            q_r[1]  <= '0;
            q_r[2]  <= '0;
            q_r[3]  <= '0;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_NDIV;
          end
        end
        ST_NDIV: if (div_done) begin
          issued_r <= 1'b0;
          q_r[i_r] <= n_sat;
          i_r      <= i_r + 2'd1;
          if (i_r == 2'd3) state_r <= ST_IDLE;
        end
        ST_MAT: if (mul_done) begin
          issued_r <= 1'b0;
          if (j_r[0] == 1'b0) begin
            j_r <= 2'd1;
          end else begin
            j_r        <= '0;
            mat_r[k_r] <= m_sat;
            k_r        <= k_r + 4'd1;
            if (k_r == 4'd8) state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_r   <= '{mat_r[0], mat_r[1], mat_r[2], mat_r[3], mat_r[4],
                         mat_r[5], mat_r[6], mat_r[7], mat_r[8]};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output step");

  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_SUM || state_r == ST_SCL || state_r == ST_SQ ||
                  state_r == ST_MAT))
    else $error("multiplier finished with no step waiting");

  a_root_next: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |=> (state_r == ST_NDIV || state_r == ST_IDLE))
    else $error("root completion led to a wrong step");
`endif

endmodule

[sv/gqi_smul.sv]
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// Depends on gqi_pkg.
module gqi_smul import gqi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mul_req_t    req,
  input  acc_t        init,
  input  acc_t        a,
  input  q30_t        b,
  output acc_t        acc,
  output logic        done
);

  logic       busy_r, done_r, sub_r;
  logic [4:0] cnt_r;
  acc_t       a_r, acc_r, acc_nxt;
  q30_t       b_r;
  logic       neg;

  // top bit of b carries negative weight
  assign neg     = sub_r ^ (cnt_r == 5'd31);
  assign acc_nxt = !b_r[0] ? acc_r : (neg ? acc_r - a_r : acc_r + a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= a;
      b_r   <= b;
      sub_r <= req.sub;
      if (req.clr) acc_r <= init;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >>> 1;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[sv/gqi_sdiv.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gqi_pkg.
module gqi_sdiv import gqi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [31:0]      den,
  output logic [ACC_W-1:0] quot,
  output logic             done
);

  logic             busy_r, done_r, ge;
  logic [6:0]       cnt_r;
  logic [ACC_W-1:0] n_r;
  logic [31:0]      rem_r, d_r;
  logic [32:0]      rem_sh, diff;

  assign rem_sh = {rem_r, n_r[ACC_W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      n_r   <= {n_r[ACC_W-2:0], ge};
    end
  end

  assign quot = n_r;
  assign done = done_r;

endmodule

[sv/gqi_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// No package dependencies.
module gqi_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n,
  output logic [31:0] root,
  output logic        done
);

  logic        busy_r, done_r, ge;
  logic [4:0]  cnt_r;
  logic [63:0] n_r;
  logic [35:0] rem_r, rem_sh, trial;
  logic [31:0] root_r;

  assign rem_sh = {rem_r[33:0], n_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], ge};
      n_r    <= {n_r[61:0], 2'b00};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule
